@@ design/mexp_pkg.sv @@
// Shared types and constants for the modular exponentiation unit.
// No dependencies; imported by mexp_mulmod and modular_exponentiation_unit.
`default_nettype none

package mexp_pkg;

    // operand width of the arithmetic; item fields are fixed at FIELD_W bits
    localparam int WIDTH   = 32;
    localparam int FIELD_W = 32;
    localparam int CNT_W   = $clog2(WIDTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAUNCH,
        S_WAIT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_RED,
        OP_MUL,
        OP_SQR
    } t_op;

endpackage

`default_nettype wire

@@ design/mexp_mulmod.sv @@
// Interleaved multiply-reduce unit: x * y mod m, one multiplier bit per cycle, MSB first.
// Depends on mexp_pkg. Requires x < m and m > 1.
`default_nettype none

module mexp_mulmod
    import mexp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WIDTH-1:0] i_x,
    input  wire logic [WIDTH-1:0] i_y,
    input  wire logic [WIDTH-1:0] i_m,
    output logic                  o_done,
    output logic [WIDTH-1:0]      o_result
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_x;
    logic [WIDTH-1:0] r_y;

    logic [WIDTH+1:0] sum;
    logic [WIDTH+1:0] m1;
    logic [WIDTH+1:0] m2;
    logic [WIDTH-1:0] n_acc;

    // 2*acc + x stays below 3m: take off m or 2m in one step
    always_comb begin
        m1  = {2'b00, i_m};
        m2  = {1'b0, i_m, 1'b0};
        sum = {1'b0, r_acc, 1'b0} + (r_y[WIDTH-1] ? {2'b00, r_x} : '0);
        priority if (sum >= m2) begin
            n_acc = WIDTH'(sum - m2);
        end else if (sum >= m1) begin
            n_acc = WIDTH'(sum - m1);
        end else begin
            n_acc = WIDTH'(sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_x   <= i_x;
            r_y   <= i_y;
            r_cnt <= CNT_W'(WIDTH);
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_y   <= {r_y[WIDTH-2:0], 1'b0};
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

`default_nettype wire

@@ design/modular_exponentiation_unit.sv @@
// Modular exponentiation unit: base^exponent mod modulus by right-to-left square-and-multiply.
// Depends on mexp_pkg and mexp_mulmod (the shared multiply-reduce unit).
//
// Usage:
//   Input channel i_in_valid / o_in_stall carries base, exponent and modulus. An item is
//   taken when i_in_valid is high and o_in_stall low; o_in_stall stays high while an item
//   is being worked on. Output channel o_out_valid / i_out_stall carries power_mod and
//   modulus_zero, one result per item, held in an output register.
//   For a modulus of zero or one, or a zero exponent, the item goes from idle straight
//   to the done state and then to the output register, with no product run.
//   Otherwise every modular product runs launch, WIDTH steps in the one shared
//   multiply-reduce unit and hand-back: one for reducing the base, then per exponent
//   bit up to the highest one bit a square, plus a multiply on each one bit (the last
//   square is skipped). With WIDTH = 32 that is at most 64 products, fewer for short
//   exponents; the next item is taken only once the result is in the output register.
//   A zero modulus raises o_modulus_zero with o_power_mod at 0.
//   The output register lets a new item start while a result waits; a finished result
//   waits in place while the previous one is stalled. Reset drops all items in flight.
`default_nettype none

module modular_exponentiation_unit
    import mexp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [FIELD_W-1:0] i_base,
    input  wire logic [FIELD_W-1:0] i_exponent,
    input  wire logic [FIELD_W-1:0] i_modulus,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [FIELD_W-1:0]      o_power_mod,
    output logic                    o_modulus_zero
);

    t_state           r_state;
    t_state           n_state;
    t_op              r_op;
    t_op              n_op;
    logic [WIDTH-1:0] r_e;
    logic [WIDTH-1:0] r_m;
    logic [WIDTH-1:0] r_sq;
    logic [WIDTH-1:0] r_acc;
    logic             r_zero;
    logic             r_out_valid;
    logic [WIDTH-1:0] r_out_pm;
    logic             r_out_zero;

    logic [WIDTH-1:0] in_m;
    logic [WIDTH-1:0] in_e;
    logic             in_short;
    logic [WIDTH-1:0] e_next;
    logic             finish;
    logic             accept;
    logic             out_load;
    logic             mm_start;
    logic [WIDTH-1:0] mm_x;
    logic [WIDTH-1:0] mm_y;
    logic             mm_done;
    logic [WIDTH-1:0] mm_res;

    assign in_m     = WIDTH'(i_modulus);
    assign in_e     = WIDTH'(i_exponent);
    assign in_short = (in_m <= WIDTH'(1)) || (in_e == '0);
    assign e_next   = r_e >> 1;

    // pick the following product and decide whether the scan is over
    always_comb begin
        n_op   = r_op;
        finish = 1'b0;
        unique case (r_op)
            OP_RED: begin
                n_op = r_e[0] ? OP_MUL : OP_SQR;
            end
            OP_MUL: begin
                n_op   = OP_SQR;
                finish = (e_next == '0);
            end
            OP_SQR: begin
                n_op   = e_next[0] ? OP_MUL : OP_SQR;
                finish = (e_next == '0);
            end
            default: begin
                n_op = OP_RED;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = in_short ? S_DONE : S_LAUNCH;
                end
            end
            S_LAUNCH: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (mm_done) begin
                    n_state = finish ? S_DONE : S_LAUNCH;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        accept   = 1'b0;
        out_load = 1'b0;
        mm_start = 1'b0;
        mm_x     = r_sq;
        mm_y     = r_sq;
        unique case (r_state)
            S_IDLE:   accept   = i_in_valid;
            S_LAUNCH: mm_start = 1'b1;
            S_WAIT:   mm_start = 1'b0;
            S_DONE:   out_load = !r_out_valid || !i_out_stall;
            default:  accept   = 1'b0;
        endcase
        unique case (r_op)
            OP_RED: begin
                mm_x = WIDTH'(1);
                mm_y = r_sq;
            end
            OP_MUL: begin
                mm_x = r_acc;
                mm_y = r_sq;
            end
            default: begin
                mm_x = r_sq;
                mm_y = r_sq;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_e    <= in_e;
            r_m    <= in_m;
            r_sq   <= WIDTH'(i_base);
            r_op   <= OP_RED;
            r_zero <= (in_m == '0);
            // zero or unit modulus gives 0; a zero exponent gives 1
            r_acc  <= (in_m <= WIDTH'(1)) ? '0 : WIDTH'(1);
        end else if (r_state == S_WAIT && mm_done) begin
            r_op <= n_op;
            unique case (r_op)
                OP_RED: r_sq <= mm_res;
                OP_MUL: r_acc <= mm_res;
                default: begin
                    r_sq <= mm_res;
                    r_e  <= e_next;
                end
            endcase
        end
        if (out_load) begin
            r_out_pm   <= r_acc;
            r_out_zero <= r_zero;
        end
    end

    mexp_mulmod u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mm_start),
        .i_x      (mm_x),
        .i_y      (mm_y),
        .i_m      (r_m),
        .o_done   (mm_done),
        .o_result (mm_res)
    );

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_power_mod    = FIELD_W'(r_out_pm);
    assign o_modulus_zero = r_out_zero;

    a_zero_mod_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_modulus_zero) |-> (o_power_mod == '0))
        else $error("zero modulus result is not zero");

    a_unit_runs_on_big_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT || r_state == S_LAUNCH) |-> (r_m > WIDTH'(1)))
        else $error("product started with modulus below two");

    a_mul_on_one_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAUNCH && r_op == OP_MUL) |-> r_e[0])
        else $error("multiply launched on a zero exponent bit");

    a_product_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT && mm_done) |-> (mm_res < r_m))
        else $error("product not reduced below modulus");

    a_start_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_start |=> !mm_done)
        else $error("product finished right after start");

endmodule

`default_nettype wire
